// ===== hw/rtl/strs_pkg.sv =====
// Shared types and constants for the segment tree range-sum block.
// Depends on nothing; every other file of the block imports it.
package strs_pkg;

  localparam int SUM_BITS   = 42;   // width of every tree node and of a result
  localparam int COUNT_BITS = 11;   // element_count register
  localparam int INDEX_BITS = 10;   // element and query index fields
  localparam int ADDR_BITS  = 3;    // configuration byte address
  localparam int DATA_BITS  = 32;   // configuration data

  // request kinds
  localparam logic KIND_LOAD = 1'b0;

  // register index (byte address / 4)
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  // walk phase of one stack frame
  localparam logic [1:0] PH_LEFT  = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  typedef struct packed {
    logic load;         // write one element from the request ports
    logic latch_query;  // capture the query bounds
    logic init_build;   // put the root frame on the stack, clear the running sum
    logic init_query;
    logic clear_sum;    // empty range: result is zero
    logic step;         // advance the walk by one frame action
    logic read_done;    // memory data is back: fold it in and pop
    logic build_mode;   // walk builds the tree rather than querying it
  } strs_cmd_t;

  typedef struct packed {
    logic need_read;    // top frame wants a memory word
    logic pop_now;      // top frame finishes in this cycle
    logic at_root;      // stack holds only the root frame
    logic empty;        // clipped query range is empty
  } strs_status_t;

endpackage

// ===== hw/rtl/strs_dpath.sv =====
// Datapath of the range-sum block: element and tree memories, walk stack,
// running sum. Depends on strs_pkg; driven by strs_ctrl commands.
module strs_dpath #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                                  clk,
  input  strs_pkg::strs_cmd_t                   cmd,
  output strs_pkg::strs_status_t                st,
  input  logic [strs_pkg::INDEX_BITS-1:0]       in_element_index,
  input  logic signed [ELEMENT_BITS-1:0]        in_element_value,
  input  logic [strs_pkg::INDEX_BITS-1:0]       in_query_low,
  input  logic [strs_pkg::INDEX_BITS-1:0]       in_query_high,
  input  logic [strs_pkg::COUNT_BITS-1:0]       element_count,
  output logic signed [strs_pkg::SUM_BITS-1:0]  range_sum
);
  import strs_pkg::*;

  localparam int AW         = $clog2(MAX_ELEMENTS);
  localparam int TREE_DEPTH = 4 * MAX_ELEMENTS;
  localparam int NW         = $clog2(TREE_DEPTH);
  localparam int LVL        = AW + 1;
  localparam int SPW        = $clog2(LVL);

  // memories
  logic signed [ELEMENT_BITS-1:0] elem_mem [MAX_ELEMENTS];
  logic signed [SUM_BITS-1:0]     tree_mem [TREE_DEPTH];
  logic signed [ELEMENT_BITS-1:0] elem_rd_r;
  logic signed [SUM_BITS-1:0]     tree_rd_r;

  // walk stack, one frame per tree level
  logic [AW-1:0]              fa_r     [LVL];
  logic [AW-1:0]              fb_r     [LVL];
  logic [NW-1:0]              fnode_r  [LVL];
  logic [1:0]                 fph_r    [LVL];
  logic signed [SUM_BITS-1:0] fentry_r [LVL];
  logic [SPW-1:0]             sp_r;
  logic signed [SUM_BITS-1:0] run_r;

  logic [INDEX_BITS-1:0] lo_raw_r;
  logic [INDEX_BITS-1:0] hi_raw_r;

  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              hi_clip;
  logic [AW-1:0]              lo_w;
  logic [AW-1:0]              ta;
  logic [AW-1:0]              tb;
  logic [AW-1:0]              mid;
  logic [NW-1:0]              tnode;
  logic [1:0]                 tph;
  logic signed [SUM_BITS-1:0] tentry;
  logic [SPW-1:0]             sp_up;
  logic                       covered;
  logic                       disjoint;
  logic                       is_leaf;
  logic                       idx_ok;
  logic signed [SUM_BITS-1:0] elem_ext;
  logic signed [SUM_BITS-1:0] rd_val;

  // clip the configured count to 1 .. MAX_ELEMENTS, kept as n-1
  always_comb begin
    if (element_count == '0) begin
      last_idx = '0;
    end else if (32'(element_count) > MAX_ELEMENTS) begin
      last_idx = AW'(MAX_ELEMENTS - 1);
    end else begin
      last_idx = AW'(element_count - COUNT_BITS'(1));
    end
  end

  always_comb begin
    if (32'(hi_raw_r) > 32'(last_idx)) begin
      hi_clip = last_idx;
    end else begin
      hi_clip = AW'(hi_raw_r);
    end
  end

  assign lo_w   = AW'(lo_raw_r);
  assign idx_ok = 32'(in_element_index) < MAX_ELEMENTS;

  assign ta     = fa_r[sp_r];
  assign tb     = fb_r[sp_r];
  assign tnode  = fnode_r[sp_r];
  assign tph    = fph_r[sp_r];
  assign tentry = fentry_r[sp_r];
  assign sp_up  = sp_r + SPW'(1);
  assign mid    = AW'(((AW+1)'(ta) + (AW+1)'(tb)) >> 1);

  assign is_leaf  = (ta == tb);
  assign covered  = (lo_w <= ta) && (tb <= hi_clip);
  assign disjoint = (lo_w > tb) || (hi_clip < ta);

  assign elem_ext = SUM_BITS'(elem_rd_r);
  assign rd_val   = cmd.build_mode ? elem_ext : tree_rd_r;

  always_comb begin
    st.need_read = (tph == PH_LEFT) && (cmd.build_mode ? is_leaf : covered);
    st.pop_now   = (tph == PH_DONE) ||
                   (!cmd.build_mode && (tph == PH_LEFT) && !covered && disjoint);
    st.at_root   = (sp_r == '0);
    st.empty     = 32'(lo_raw_r) > 32'(hi_clip);
  end

  assign range_sum = run_r;

  always_ff @(posedge clk) begin
    if (cmd.load && idx_ok) begin
      elem_mem[AW'(in_element_index)] <= in_element_value;
    end
    elem_rd_r <= elem_mem[ta];
  end

  // a node's sum is the growth of the running sum across its subtree
  always_ff @(posedge clk) begin
    if (cmd.build_mode && cmd.step && !st.need_read && st.pop_now) begin
      tree_mem[tnode] <= run_r - tentry;
    end else if (cmd.build_mode && cmd.read_done) begin
      tree_mem[tnode] <= elem_ext;
    end
    tree_rd_r <= tree_mem[tnode];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_query) begin
      lo_raw_r <= in_query_low;
      hi_raw_r <= in_query_high;
    end
    if (cmd.init_build || cmd.init_query) begin
      sp_r        <= '0;
      fa_r[0]     <= '0;
      fb_r[0]     <= last_idx;
      fnode_r[0]  <= '0;
      fph_r[0]    <= PH_LEFT;
      fentry_r[0] <= '0;
      run_r       <= '0;
    end else if (cmd.clear_sum) begin
      run_r <= '0;
    end else if (cmd.read_done) begin
      run_r <= run_r + rd_val;
      if (!st.at_root) begin
        sp_r <= sp_r - SPW'(1);
      end
    end else if (cmd.step && !st.need_read) begin
      if (st.pop_now) begin
        if (!st.at_root) begin
          sp_r <= sp_r - SPW'(1);
        end
      end else begin
        // push the next child
        fph_r[sp_up]    <= PH_LEFT;
        fentry_r[sp_up] <= run_r;
        sp_r            <= sp_up;
        if (tph == PH_LEFT) begin
          fa_r[sp_up]    <= ta;
          fb_r[sp_up]    <= mid;
          fnode_r[sp_up] <= NW'(tnode * 2 + 1);
          fph_r[sp_r]    <= PH_RIGHT;
        end else begin
          fa_r[sp_up]    <= mid + AW'(1);
          fb_r[sp_up]    <= tb;
          fnode_r[sp_up] <= NW'(tnode * 2 + 2);
          fph_r[sp_r]    <= PH_DONE;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/strs_ctrl.sv =====
// Controller of the range-sum block: request acceptance, build and query
// sequencing, result strobe. Depends on strs_pkg; drives strs_dpath.
module strs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   kind,
  input  logic                   cfg_wr,
  input  strs_pkg::strs_status_t st,
  output strs_pkg::strs_cmd_t    cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import strs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BSTART = 3'd1;
  localparam logic [2:0] S_BWALK  = 3'd2;
  localparam logic [2:0] S_BWAIT  = 3'd3;
  localparam logic [2:0] S_QSTART = 3'd4;
  localparam logic [2:0] S_QWALK  = 3'd5;
  localparam logic [2:0] S_QWAIT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       stale_r, stale_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    stale_nxt = stale_r;
    valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_LOAD) begin
            cmd.load  = 1'b1;
            stale_nxt = 1'b1;
          end else begin
            cmd.latch_query = 1'b1;
            state_nxt       = stale_r ? S_BSTART : S_QSTART;
          end
        end
      end
      S_BSTART: begin
        cmd.init_build = 1'b1;
        cmd.build_mode = 1'b1;
        stale_nxt      = 1'b0;
        state_nxt      = S_BWALK;
      end
      S_BWALK: begin
        cmd.step       = 1'b1;
        cmd.build_mode = 1'b1;
        if (st.need_read) begin
          state_nxt = S_BWAIT;
        end else if (st.pop_now && st.at_root) begin
          state_nxt = S_QSTART;
        end
      end
      S_BWAIT: begin
        cmd.read_done  = 1'b1;
        cmd.build_mode = 1'b1;
        state_nxt      = st.at_root ? S_QSTART : S_BWALK;
      end
      S_QSTART: begin
        if (st.empty) begin
          cmd.clear_sum = 1'b1;
          valid_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.init_query = 1'b1;
          state_nxt      = S_QWALK;
        end
      end
      S_QWALK: begin
        cmd.step = 1'b1;
        if (st.need_read) begin
          state_nxt = S_QWAIT;
        end else if (st.pop_now && st.at_root) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_QWAIT: begin
        cmd.read_done = 1'b1;
        if (st.at_root) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_QWALK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_wr) begin
      stale_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stale_r <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stale_r <= stale_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  a_fresh_only_by_build: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(stale_r) |-> ($past(state_r) == S_BSTART))
    else $error("tree marked fresh without a build");

  a_bwait_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BWAIT) |-> ($past(state_r) == S_BWALK))
    else $error("build read wait not issued by walk");

  a_qwait_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QWAIT) |-> ($past(state_r) == S_QWALK))
    else $error("query read wait not issued by walk");

endmodule

// ===== hw/rtl/segment_tree_range_sum.sv =====
// Top level of the segment tree range-sum block: APB register, controller
// and datapath. Depends on strs_pkg, strs_ctrl and strs_dpath.
//
//   channel   ports                                   handshake
//   request   in_kind, in_element_index,              start & !busy
//             in_element_value, in_query_low/high
//   result    out_range_sum                           out_valid, one cycle
//   config    psel penable pwrite paddr pwdata        write on access phase
//             prdata pready                           pready tied high
//
// A load request leaves busy low, so loads run back to back. A query
// passes a setup state, then walks the tree one frame at a time over one
// tree memory port: a split node pushes its left child, then its right,
// then pops; a node read whole issues a read and waits for it; a node
// outside the range pops at once. The first query after a load or a
// count write first builds the tree. The strobe is registered and comes
// in the cycle after the query finishes; the receiver cannot stall it.
// Reset clears control only: both memories need no clearing pass.
module segment_tree_range_sum #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_kind,
  input  logic [strs_pkg::INDEX_BITS-1:0]       in_element_index,
  input  logic signed [ELEMENT_BITS-1:0]        in_element_value,
  input  logic [strs_pkg::INDEX_BITS-1:0]       in_query_low,
  input  logic [strs_pkg::INDEX_BITS-1:0]       in_query_high,
  output logic                                  out_valid,
  output logic signed [strs_pkg::SUM_BITS-1:0]  out_range_sum,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [strs_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [strs_pkg::DATA_BITS-1:0]        pwdata,
  output logic [strs_pkg::DATA_BITS-1:0]        prdata,
  output logic                                  pready
);
  import strs_pkg::*;

  strs_cmd_t    cmd;
  strs_status_t st;

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  reg_hit;
  logic                  cfg_wr;

  // one register at word 0; a write elsewhere is dropped
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_BITS-1:2] == REG_ELEMENT_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;

  always_comb begin
    count_nxt = count_r;
    if (cfg_wr) begin
      count_nxt = pwdata[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_BITS'(1);
    end else begin
      count_r <= count_nxt;
    end
  end

  assign prdata = reg_hit ? DATA_BITS'(count_r) : '0;

  // sequence requests; the stale mark lives in the controller
  strs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_kind),
    .cfg_wr    (cfg_wr),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // hold memories, walk stack and running sum
  strs_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dpath (
    .clk              (clk),
    .cmd              (cmd),
    .st               (st),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .in_query_low     (in_query_low),
    .in_query_high    (in_query_high),
    .element_count    (count_r),
    .range_sum        (out_range_sum)
  );

endmodule

// ===== verif/segment_tree_range_sum_tb.sv =====
// Self-checking testbench for segment_tree_range_sum: element loads, range-sum queries
// and element_count settings, checked against a behavioural mirror of the element array.
// Depends on strs_pkg and the segment_tree_range_sum RTL.
`timescale 1ns / 100ps

module segment_tree_range_sum_tb;
  import strs_pkg::*;

  localparam int MAX_ELEMENTS   = 1024;
  localparam int ITEM_TARGET    = 1550;   // requests after the directed cases, bulk fill included
  localparam int SETTLE_CYCLES  = 16;     // loads leave busy low; allow ample margin
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 40000;  // several full rebuilds at 1024 elements

  localparam logic KIND_QUERY = ~KIND_LOAD;
  // byte address of register i is 4*i
  localparam logic [ADDR_BITS-1:0] ADDR_COUNT = {REG_ELEMENT_COUNT, 2'b00};
  localparam logic [ADDR_BITS-1:0] ADDR_SPARE = {~REG_ELEMENT_COUNT, 2'b00};

  localparam logic signed [31:0] ELEM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ELEM_MIN = 32'sh8000_0000;

  typedef struct {
    logic                   kind;
    logic [INDEX_BITS-1:0]  index;
    logic signed [31:0]     value;
    logic [INDEX_BITS-1:0]  low;
    logic [INDEX_BITS-1:0]  high;
  } tree_request_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                         start            = 1'b0;
  logic                         busy;
  logic                         in_kind          = KIND_LOAD;
  logic [INDEX_BITS-1:0]        in_element_index = '0;
  logic signed [31:0]           in_element_value = '0;
  logic [INDEX_BITS-1:0]        in_query_low     = '0;
  logic [INDEX_BITS-1:0]        in_query_high    = '0;
  logic                         out_valid;
  logic signed [SUM_BITS-1:0]   out_range_sum;
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [ADDR_BITS-1:0]         paddr   = '0;
  logic [DATA_BITS-1:0]         pwdata  = '0;
  logic [DATA_BITS-1:0]         prdata;
  logic                         pready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_tree_range_sum DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .in_query_low     (in_query_low),
    .in_query_high    (in_query_high),
    .out_valid        (out_valid),
    .out_range_sum    (out_range_sum),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the block's state and the stores that link stimulus to checks
  // ---------------------------------------------------------------------------
  longint                  element_mirror [MAX_ELEMENTS];  // written by the driver only
  logic [COUNT_BITS-1:0]   count_mirror = 11'd1;           // written between phases only
  bit                      gen_written [MAX_ELEMENTS];     // loads already queued, per index

  tree_request_t               pending_requests [$];
  logic signed [SUM_BITS-1:0]  expected_sums [$];
  tree_request_t               next_request;

  int fault_count      = 0;
  int issued_items     = 0;
  int loads_accepted   = 0;
  int queries_accepted = 0;
  int results_checked  = 0;
  int settings_seen    = 0;
  int burst_left       = 1;
  int gap_left         = 0;
  int quiet_cycles     = 0;

  // Report the first few faults in full; count the rest silently.
  function automatic void flag_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", what);
  endfunction

  // Zero counts as one element, anything past the array is clipped to it.
  function automatic int unsigned active_length(logic [COUNT_BITS-1:0] word);
    if (word == '0) return 1;
    if (32'(word) > MAX_ELEMENTS) return MAX_ELEMENTS;
    return 32'(word);
  endfunction

  // Any split of the range into tree nodes adds up to the plain sum, and 42 bits
  // hold the sum of 1024 elements, so sum the mirror directly.
  function automatic logic signed [SUM_BITS-1:0] predict_range_sum(
      logic [INDEX_BITS-1:0] lo, logic [INDEX_BITS-1:0] hi);
    int unsigned n;
    int unsigned top;
    longint      acc;
    n   = active_length(count_mirror);
    top = (32'(hi) > n - 1) ? n - 1 : 32'(hi);
    acc = 0;
    for (int unsigned i = 32'(lo); i <= top; i++) acc += element_mirror[i];
    return acc[SUM_BITS-1:0];
  endfunction

  // Favour the extremes and values near zero over plain random words.
  function automatic logic signed [31:0] rand_element();
    int near_zero;
    near_zero = int'($urandom_range(16, 0)) - 8;
    case ($urandom_range(9, 0))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return near_zero;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation: query fields ride along with loads at random, and back
  // ---------------------------------------------------------------------------
  task automatic queue_load(logic [INDEX_BITS-1:0] idx, logic signed [31:0] val);
    tree_request_t req;
    req.kind  = KIND_LOAD;
    req.index = idx;
    req.value = val;
    req.low   = INDEX_BITS'($urandom_range(1023, 0));
    req.high  = INDEX_BITS'($urandom_range(1023, 0));
    gen_written[idx] = 1'b1;
    pending_requests.push_back(req);
    issued_items++;
  endtask

  task automatic queue_query(logic [INDEX_BITS-1:0] lo, logic [INDEX_BITS-1:0] hi);
    tree_request_t req;
    req.kind  = KIND_QUERY;
    req.index = INDEX_BITS'($urandom_range(1023, 0));
    req.value = $urandom;
    req.low   = lo;
    req.high  = hi;
    pending_requests.push_back(req);
    issued_items++;
  endtask

  // Mostly well-formed ranges inside the array; the rest overhang it, are
  // empty, are arbitrary or span the whole index space.
  task automatic queue_random_query(int unsigned n);
    logic [INDEX_BITS-1:0] lo;
    logic [INDEX_BITS-1:0] hi;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: begin
        lo = INDEX_BITS'($urandom_range(n - 1, 0));
        hi = INDEX_BITS'($urandom_range(n - 1, 32'(lo)));
      end
      6: begin
        lo = INDEX_BITS'($urandom_range(n - 1, 0));
        hi = INDEX_BITS'($urandom_range(1023, n - 1));
      end
      7: begin
        if (n > 1) begin
          hi = INDEX_BITS'($urandom_range(n - 2, 0));
          lo = INDEX_BITS'($urandom_range(1023, 32'(hi) + 1));
        end else begin
          lo = INDEX_BITS'($urandom_range(1023, 1));
          hi = INDEX_BITS'($urandom_range(1023, 0));
        end
      end
      8: begin
        lo = INDEX_BITS'($urandom_range(1023, 0));
        hi = INDEX_BITS'($urandom_range(1023, 0));
      end
      default: begin
        lo = '0;
        hi = '1;
      end
    endcase
    queue_query(lo, hi);
  endtask

  // Most loads land on elements in use; the rest anywhere in the array.
  task automatic queue_random_load(int unsigned n);
    logic [INDEX_BITS-1:0] idx;
    idx = ($urandom_range(9, 0) < 6) ? INDEX_BITS'($urandom_range(n - 1, 0))
                                     : INDEX_BITS'($urandom_range(1023, 0));
    queue_load(idx, rand_element());
  endtask

  // ---------------------------------------------------------------------------
  // Register port: setup then access phase; leave on a falling edge so that
  // requests queued afterwards never race the driver
  // ---------------------------------------------------------------------------
  task automatic apb_transfer(logic [ADDR_BITS-1:0] addr, logic wr,
                              logic [DATA_BITS-1:0] wdata, output logic [DATA_BITS-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every queued request is taken and every sum has come back,
  // then let the block settle; only then is a register write safe.
  task automatic wait_quiet();
    do @(negedge clk); while (pending_requests.size() != 0 || start || expected_sums.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Write the count with junk in the unused upper bits, read it back, and
  // queue loads for any element in use that was never written.
  task automatic set_element_count(logic [COUNT_BITS-1:0] word);
    logic [DATA_BITS-1:0] data;
    logic [DATA_BITS-1:0] rd;
    int unsigned          n;
    data = ($urandom & ~32'h7FF) | DATA_BITS'(word);
    apb_transfer(ADDR_COUNT, 1'b1, data, rd);
    count_mirror = word;
    apb_transfer(ADDR_COUNT, 1'b0, '0, rd);
    if (rd[COUNT_BITS-1:0] !== word)
      flag_fault($sformatf("element_count readback expected %0d got %0d",
                           word, rd[COUNT_BITS-1:0]));
    settings_seen++;
    n = active_length(word);
    for (int unsigned i = 0; i < n; i++)
      if (!gen_written[i]) queue_load(INDEX_BITS'(i), rand_element());
  endtask

  // ---------------------------------------------------------------------------
  // Driver: take requests from the queue in bursts with random gaps. A request
  // counts as taken at the edge where start is high and busy is low; predict
  // its effect right there, in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      gap_left   <= 0;
      burst_left <= 1;
    end else begin
      if (start && !busy) begin
        if (in_kind == KIND_LOAD) begin
          element_mirror[in_element_index] = longint'(in_element_value);
          loads_accepted++;
        end else begin
          expected_sums.push_back(predict_range_sum(in_query_low, in_query_high));
          queries_accepted++;
        end
      end
      // a request the block has not taken yet stays on the ports unchanged
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_requests.size() != 0) begin
          next_request = pending_requests.pop_front();
          in_kind          <= next_request.kind;
          in_element_index <= next_request.index;
          in_element_value <= next_request.value;
          in_query_low     <= next_request.low;
          in_query_high    <= next_request.high;
          start            <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            // occasional long stretches with no idling, otherwise short bursts
            burst_left <= ($urandom_range(7, 0) == 0) ? $urandom_range(200, 50)
                                                      : $urandom_range(12, 1);
            gap_left   <= ($urandom_range(3, 0) == 0) ? $urandom_range(12, 4)
                                                      : $urandom_range(2, 0);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each strobed sum must match the oldest outstanding prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_sums.size() == 0) begin
        flag_fault($sformatf("unexpected range_sum %0d", out_range_sum));
      end else begin
        if (out_range_sum !== expected_sums[0])
          flag_fault($sformatf("range_sum expected %0d got %0d",
                               expected_sums[0], out_range_sum));
        void'(expected_sums.pop_front());
        results_checked++;
      end
    end
  end

  // Watchdog: any request, result or register access restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d sums outstanding",
                 quiet_cycles, expected_sums.size());
        $display("FAIL segment_tree_range_sum");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed corner cases, then random phases over a range of
  // element counts, each phase closed by a quiet point before the next write
  // ---------------------------------------------------------------------------
  initial begin
    logic [COUNT_BITS-1:0] count_word;
    logic [DATA_BITS-1:0]  rd;
    int unsigned           n;
    int                    phase;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single element after reset: extremes, overhanging and empty ranges
    queue_load(10'd0, ELEM_MAX);
    queue_query(10'd0, 10'd0);
    queue_query(10'd0, 10'd1023);
    queue_query(10'd1, 10'd1023);
    queue_query(10'd1023, 10'd0);
    wait_quiet();

    // a zero count acts as one element; repeat a query without a rebuild
    set_element_count(11'd0);
    queue_load(10'd0, ELEM_MIN);
    queue_query(10'd0, 10'd0);
    queue_query(10'd0, 10'd0);
    wait_quiet();

    // a write to the unused address leaves the count alone
    apb_transfer(ADDR_SPARE, 1'b1, 32'hFFFF_FFFF, rd);
    queue_query(10'd0, 10'd1023);
    queue_load(10'd1, ELEM_MAX);
    wait_quiet();

    // count change forces a rebuild over two elements
    set_element_count(11'd2);
    queue_query(10'd0, 10'd1);
    queue_query(10'd1, 10'd1);
    queue_query(10'd1, 10'd0);
    queue_query(10'd0, 10'd0);
    queue_load(10'd0, 32'sd0);
    queue_query(10'd0, 10'd1023);
    queue_load(10'd1, -32'sd1);
    queue_query(10'd1, 10'd1023);
    wait_quiet();

    issued_items = 0;
    phase = 0;
    while (issued_items < ITEM_TARGET) begin
      if (phase == 1) begin
        // fill the whole array with the most negative value: the widest sum
        for (int i = 0; i < MAX_ELEMENTS; i++) queue_load(INDEX_BITS'(i), ELEM_MIN);
        wait_quiet();
        count_word = COUNT_BITS'(MAX_ELEMENTS);
      end else if (phase == 4) begin
        count_word = '1;
      end else if (phase == 7) begin
        count_word = COUNT_BITS'($urandom_range(2046, 1025));
      end else if (phase == 10) begin
        count_word = '0;
      end else if (phase % 3 == 2) begin
        count_word = COUNT_BITS'($urandom_range(300, 41));
      end else begin
        count_word = COUNT_BITS'($urandom_range(40, 1));
      end
      set_element_count(count_word);
      n = active_length(count_word);

      if (phase == 1) begin
        queue_query(10'd0, 10'd1023);
        queue_query(10'd0, 10'd511);
        queue_query(10'd512, 10'd1023);
        queue_query(10'd1023, 10'd1023);
        queue_query(10'd300, 10'd200);
      end

      if (n > 256) begin
        // large trees rebuild slowly: batch the loads between query runs
        repeat (5) begin
          repeat ($urandom_range(3, 1)) queue_random_load(n);
          repeat ($urandom_range(8, 3)) queue_random_query(n);
        end
      end else begin
        repeat ($urandom_range(70, 30)) begin
          if ($urandom_range(9, 0) < 4) queue_random_load(n);
          else queue_random_query(n);
        end
      end

      if (phase % 5 == 3) begin
        wait_quiet();
        apb_transfer(ADDR_SPARE, 1'b1, $urandom, rd);
      end
      wait_quiet();
      phase++;
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_sums.size() != 0)
      flag_fault($sformatf("%0d range sums never arrived", expected_sums.size()));

    $display("covered %0d loads and %0d queries (%0d sums checked) over %0d count settings",
             loads_accepted, queries_accepted, results_checked, settings_seen);
    $display("%0d faults found", fault_count);
    if (fault_count == 0) begin
      $display("PASS segment_tree_range_sum");
    end else begin
      $display("FAIL segment_tree_range_sum");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/strs_pkg.sv
hw/rtl/strs_dpath.sv
hw/rtl/strs_ctrl.sv
hw/rtl/segment_tree_range_sum.sv
verif/segment_tree_range_sum_tb.sv
